@@ sv/i2rt_pkg.sv @@
// ----------------------------------------------------------------------------
// i2rt_pkg
// Shared types and constants for the integer to radix text converter.
// ----------------------------------------------------------------------------
package i2rt_pkg;

  localparam int MaxSymbols = 64;
  localparam int SymIdxW    = $clog2(MaxSymbols);
  localparam int DigitDepth = 32;
  localparam int DigitIdxW  = $clog2(DigitDepth);
  localparam int DigCntW    = $clog2(DigitDepth + 1);
  localparam int DataW      = 32;
  localparam int DivCntW    = $clog2(DataW + 1);
  localparam int CharW      = 8;
  localparam int LenW       = 7;
  localparam int SeenW      = 128;
  localparam int SeenIdxW   = $clog2(SeenW);

  localparam logic [CharW-1:0] CharSpace = 8'd32;
  localparam logic [CharW-1:0] CharDel   = 8'd127;
  localparam logic [CharW-1:0] CharPlus  = 8'd43;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdConvert = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [SymIdxW-1:0]      symbol_index;
    logic [CharW-1:0]        symbol_char;
    logic signed [DataW-1:0] number;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             invalid;
    logic             last;
  } out_t;

  typedef struct packed {
    logic               we;
    logic [SymIdxW-1:0] waddr;
    logic [CharW-1:0]   wdata;
    logic               re;
    logic [SymIdxW-1:0] raddr;
  } tab_req_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [LenW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quot;
    logic [LenW-1:0]  rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StChkRd,
    StChkEv,
    StDivGo,
    StDivWait,
    StSign,
    StDigRd,
    StDigOut,
    StInvalid
  } state_e;

  function automatic logic symbol_ok(logic [CharW-1:0] c);
    symbol_ok = (c > CharSpace) && (c < CharDel) && (c != CharPlus) && (c != CharMinus);
  endfunction

endpackage

@@ sv/i2rt_symtab.sv @@
// ----------------------------------------------------------------------------
// i2rt_symtab
// Symbol table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module i2rt_symtab (
  input  logic                        clk_i,
  input  i2rt_pkg::tab_req_t          req_i,
  output logic [i2rt_pkg::CharW-1:0]  rdata_o
);
  import i2rt_pkg::*;

  logic [CharW-1:0] mem [MaxSymbols];
  logic [CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/i2rt_div.sv @@
// ----------------------------------------------------------------------------
// i2rt_div
// Restoring divider, one quotient bit per cycle, for a narrow divisor.
// ----------------------------------------------------------------------------
module i2rt_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2rt_pkg::div_req_t  req_i,
  output i2rt_pkg::div_rsp_t  rsp_o
);
  import i2rt_pkg::*;

  logic [DataW-1:0]   quot_q, quot_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [LenW-1:0]    divisor_q, divisor_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [LenW:0]      trial;

  always_comb begin
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    trial     = {rem_q, quot_q[DataW-1]};
    if (req_i.start) begin
      quot_d    = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
      cnt_d     = DivCntW'(DataW);
      busy_d    = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_q}) begin
        rem_d  = LenW'(trial - {1'b0, divisor_q});
        quot_d = {quot_q[DataW-2:0], 1'b1};
      end else begin
        rem_d  = trial[LenW-1:0];
        quot_d = {quot_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ sv/integer_to_radix_text.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts signed 32-bit numbers to text in the radix of a loaded alphabet.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Beat
//  in        input      in_valid/in_ready   load one symbol or convert a number
//  out       output     out_valid/out_ready one character, or one invalid flag
//  cfg       input      cfg_we              alphabet length, written at once
//
// A load writes one symbol into the table. A convert checks the alphabet one
// symbol at a time (read, then check), then divides once per digit in the
// bit-serial divider, then emits a sign if negative and each character (read,
// then output) while the output is free; a rejected alphabet gives one invalid beat.
// The input is not ready until the last character is in the output register.
// The output register holds its beat while out_ready_i is low.
module integer_to_radix_text (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  i2rt_pkg::in_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output i2rt_pkg::out_t           out_data_o,
  input  logic                     cfg_we_i,
  input  logic [i2rt_pkg::LenW-1:0] cfg_wdata_i
);
  import i2rt_pkg::*;

  state_e             state_q, state_d;
  logic [LenW-1:0]    len_q;
  logic [SymIdxW-1:0] chk_idx_q, chk_idx_d;
  logic [SeenW-1:0]   seen_q, seen_d;
  logic [DataW-1:0]   mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [DigCntW-1:0] cnt_q, cnt_d;
  logic [DigCntW-1:0] cnt_m1;
  logic [SymIdxW-1:0] dig_q [DigitDepth];
  logic               dig_we;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;
  logic               in_acc;
  logic               len_ok;
  logic [CharW-1:0]   rdata;
  tab_req_t           tab_req;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  i2rt_symtab u_symtab (
    .clk_i   (clk_i),
    .req_i   (tab_req),
    .rdata_o (rdata)
  );

  i2rt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign len_ok     = (len_q >= LenW'(2)) && (int'(len_q) <= MaxSymbols);
  assign cnt_m1     = cnt_q - DigCntW'(1);

  always_comb begin
    state_d     = state_q;
    chk_idx_d   = chk_idx_q;
    seen_d      = seen_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    dig_we      = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    tab_req.we    = 1'b0;
    tab_req.waddr = in_data_i.symbol_index;
    tab_req.wdata = in_data_i.symbol_char;
    tab_req.re    = 1'b0;
    tab_req.raddr = chk_idx_q;

    div_req.start    = 1'b0;
    div_req.dividend = mag_q;
    div_req.divisor  = len_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.cmd == CmdLoad) begin
            tab_req.we = (int'(in_data_i.symbol_index) < MaxSymbols);
          end else begin
            neg_d     = in_data_i.number[DataW-1];
            mag_d     = in_data_i.number[DataW-1] ? (DataW'(0) - in_data_i.number)
                                                  : in_data_i.number;
            chk_idx_d = '0;
            seen_d    = '0;
            cnt_d     = '0;
            state_d   = len_ok ? StChkRd : StInvalid;
          end
        end
      end
      StChkRd: begin
        tab_req.re = 1'b1;
        state_d    = StChkEv;
      end
      StChkEv: begin
        if (!symbol_ok(rdata) || seen_q[rdata[SeenIdxW-1:0]]) begin
          state_d = StInvalid;
        end else begin
          seen_d[rdata[SeenIdxW-1:0]] = 1'b1;
          if (LenW'(chk_idx_q) == len_q - LenW'(1)) begin
            state_d = StDivGo;
          end else begin
            chk_idx_d = chk_idx_q + SymIdxW'(1);
            state_d   = StChkRd;
          end
        end
      end
      StDivGo: begin
        div_req.start = 1'b1;
        state_d       = StDivWait;
      end
      StDivWait: begin
        if (div_rsp.done) begin
          dig_we = 1'b1;
          mag_d  = div_rsp.quot;
          cnt_d  = cnt_q + DigCntW'(1);
          if ((div_rsp.quot != '0) && (cnt_q < DigCntW'(DigitDepth - 1))) begin
            state_d = StDivGo;
          end else begin
            state_d = neg_q ? StSign : StDigRd;
          end
        end
      end
      StSign: begin
        if (out_free) begin
          out_d.out_char = CharMinus;
          out_d.invalid  = 1'b0;
          out_d.last     = 1'b0;
          out_valid_d    = 1'b1;
          state_d        = StDigRd;
        end
      end
      StDigRd: begin
        tab_req.re    = 1'b1;
        tab_req.raddr = dig_q[cnt_m1[DigitIdxW-1:0]];
        state_d       = StDigOut;
      end
      StDigOut: begin
        if (out_free) begin
          out_d.out_char = rdata;
          out_d.invalid  = 1'b0;
          out_d.last     = (cnt_q == DigCntW'(1));
          out_valid_d    = 1'b1;
          cnt_d          = cnt_m1;
          state_d        = (cnt_q == DigCntW'(1)) ? StIdle : StDigRd;
        end
      end
      StInvalid: begin
        if (out_free) begin
          out_d.out_char = '0;
          out_d.invalid  = 1'b1;
          out_d.last     = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      cnt_q       <= '0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mag_q       <= mag_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    seen_q    <= seen_d;
    neg_q     <= neg_d;
    out_q     <= out_d;
    if (dig_we) begin
      dig_q[cnt_q[DigitIdxW-1:0]] <= div_rsp.rem[SymIdxW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_invalid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid |-> out_data_o.last && (out_data_o.out_char == '0))
    else $error("Invalid beat without last or with a character.");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("Divider started while busy.");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DigCntW'(DigitDepth))
    else $error("Digit count beyond buffer depth.");

  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("Input ready while a division runs.");
`endif

endmodule

@@ verif/integer_to_radix_text_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text_tb
// Self-checking bench for the radix text converter. A directed table covers
// reset state, field extremes, too short an alphabet and each kind of bad or
// repeated symbol. Random phases then load fresh alphabets at many lengths,
// sometimes with a defect or a stray symbol beat, and convert random numbers.
// Every output beat is compared with a local model of the table and the digit
// conversion, under random gaps on both channels until 140 beats have gone in.
// ----------------------------------------------------------------------------
module integer_to_radix_text_tb;
  import i2rt_pkg::*;

  localparam int RandomBeats  = 150;
  localparam int SettleCycles = 20;
  localparam int CycleLimit   = 1_500_000;

  typedef enum logic {RowCfg, RowItem} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [6:0]  length;
    in_t         beat;
    bit          typed;
    out_t        want;
  } row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  logic [7:0]  sym_table [MaxSymbols];
  logic [6:0]  radix_len = '0;
  out_t        chars_due [$];
  out_t        want_char;
  row_t        plan [$];

  int send_gap_pct = 21;
  int recv_gap_pct = 66;
  int beats_in     = 0;
  int conversions  = 0;
  int beats_out    = 0;
  int lengths_set  = 0;
  int mismatches   = 0;
  int cycles       = 0;

  integer_to_radix_text uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Expected text for one beat: loads update the table, converts produce
  // either one rejection beat or an optional sign followed by the digits.
  task automatic predict_text(input in_t beat);
    logic [5:0]  digits [DigitDepth];
    logic [31:0] mag;
    int          n;
    bit          usable;
    if (beat.cmd == CmdLoad) begin
      sym_table[beat.symbol_index] = beat.symbol_char;
      return;
    end
    usable = (radix_len >= 2) && (radix_len <= MaxSymbols);
    for (int i = 0; usable && i < radix_len; i++) begin
      if (sym_table[i] <= CharSpace || sym_table[i] >= CharDel ||
          sym_table[i] == CharPlus || sym_table[i] == CharMinus) begin
        usable = 1'b0;
      end
      for (int j = i + 1; j < radix_len; j++) begin
        if (sym_table[i] == sym_table[j]) usable = 1'b0;
      end
    end
    if (!usable) begin
      chars_due.push_back('{out_char: 8'd0, invalid: 1'b1, last: 1'b1});
      return;
    end
    mag = beat.number[31] ? 32'd0 - beat.number : beat.number;
    n = 0;
    do begin
      digits[n] = 6'(mag % radix_len);
      mag = mag / radix_len;
      n++;
    end while (mag != 0 && n < DigitDepth);
    if (beat.number[31]) begin
      chars_due.push_back('{out_char: CharMinus, invalid: 1'b0, last: 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      chars_due.push_back('{out_char: sym_table[digits[i]], invalid: 1'b0, last: (i == 0)});
    end
  endtask

  task automatic send_beat(input in_t beat, input bit typed, input out_t want);
    if (beats_in < 70) begin
      send_gap_pct = 21;
      recv_gap_pct = 66;
    end else if (beats_in < 140) begin
      send_gap_pct = 66;
      recv_gap_pct = 21;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    beats_in++;
    if (beat.cmd == CmdConvert) conversions++;
    if (typed) begin
      chars_due.push_back(want);
    end else begin
      predict_text(beat);
    end
  endtask

  task automatic write_length(input logic [6:0] len);
    in_valid_i <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    radix_len = len;
    lengths_set++;
  endtask

  function automatic logic signed [31:0] rand_number();
    logic signed [31:0] m;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'sd0;
          1:       return -32'sd1;
          2:       return 32'sd1;
          3:       return 32'sh8000_0000;
          default: return 32'sh7fff_ffff;
        endcase
      end
      1, 2, 3: begin
        m = $urandom_range(0, 4095);
        return $urandom_range(0, 1) ? -m : m;
      end
      default: return $urandom;
    endcase
  endfunction

  // One alphabet setting: at a length of 2 to 64 load distinct shuffled symbols,
  // now and then with one defect, then convert numbers with a stray load mixed in.
  task automatic run_phase(input logic [6:0] len);
    logic [7:0] pool [92];
    logic [7:0] t;
    int         n;
    int         j;
    int         p;
    int         k;
    in_t        beat;
    write_length(len);
    if (len >= 2 && len <= MaxSymbols) begin
      n = 0;
      for (int c = 33; c < 127; c++) begin
        if (c != CharPlus && c != CharMinus) begin
          pool[n] = 8'(c);
          n++;
        end
      end
      for (int i = 91; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = pool[i];
        pool[i] = pool[j];
        pool[j] = t;
      end
      if ($urandom_range(0, 5) == 0) begin
        p = $urandom_range(0, len - 1);
        case ($urandom_range(0, 6))
          0:       pool[p] = CharSpace;
          1:       pool[p] = CharDel;
          2:       pool[p] = CharPlus;
          3:       pool[p] = CharMinus;
          4:       pool[p] = 8'($urandom_range(0, 31));
          5:       pool[p] = 8'($urandom_range(128, 255));
          default: pool[p] = pool[(p + 1) % len];
        endcase
      end
      for (int i = 0; i < len; i++) begin
        beat = '{cmd: CmdLoad, symbol_index: 6'(i), symbol_char: pool[i], number: $urandom};
        send_beat(beat, 1'b0, '0);
      end
      k = $urandom_range(5, 9);
    end else begin
      k = 3;
    end
    repeat (k) begin
      if ($urandom_range(0, 6) == 0) begin
        beat = '{cmd: CmdLoad, symbol_index: 6'($urandom_range(0, 63)),
                 symbol_char: 8'($urandom_range(0, 255)), number: $urandom};
        send_beat(beat, 1'b0, '0);
      end
      beat = '{cmd: CmdConvert, symbol_index: 6'($urandom_range(0, 63)),
               symbol_char: 8'($urandom_range(0, 255)), number: rand_number()};
      send_beat(beat, 1'b0, '0);
    end
  endtask

  function automatic row_t make_row(row_kind_e kind, logic [6:0] len, logic cmd,
                                    logic [5:0] idx, logic [7:0] ch,
                                    logic signed [31:0] num, bit typed);
    row_t r;
    r.kind  = kind;
    r.length = len;
    r.beat  = '{cmd: cmd, symbol_index: idx, symbol_char: ch, number: num};
    r.typed = typed;
    r.want  = '{out_char: 8'd0, invalid: 1'b1, last: 1'b1};
    return r;
  endfunction

  function automatic row_t length_row(logic [6:0] len);
    return make_row(RowCfg, len, CmdLoad, 6'd0, 8'd0, 32'sd0, 1'b0);
  endfunction

  function automatic row_t load_row(logic [5:0] idx, logic [7:0] ch);
    return make_row(RowItem, 7'd0, CmdLoad, idx, ch, 32'sd0, 1'b0);
  endfunction

  function automatic row_t convert_row(logic signed [31:0] num);
    return make_row(RowItem, 7'd0, CmdConvert, 6'd0, 8'd0, num, 1'b0);
  endfunction

  function automatic row_t rejected_row(logic signed [31:0] num);
    return make_row(RowItem, 7'd0, CmdConvert, 6'd0, 8'd0, num, 1'b1);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (chars_due.size() == 0) begin
        $error("unexpected output beat: out_char %0d invalid %0d last %0d",
               out_data_o.out_char, out_data_o.invalid, out_data_o.last);
        mismatches++;
      end else begin
        want_char = chars_due.pop_front();
        if (out_data_o.out_char !== want_char.out_char) begin
          $error("out_char: expected %0d, got %0d", want_char.out_char, out_data_o.out_char);
          mismatches++;
        end
        if (out_data_o.invalid !== want_char.invalid) begin
          $error("invalid: expected %0d, got %0d", want_char.invalid, out_data_o.invalid);
          mismatches++;
        end
        if (out_data_o.last !== want_char.last) begin
          $error("last: expected %0d, got %0d", want_char.last, out_data_o.last);
          mismatches++;
        end
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_gap_pct);
  end

  initial begin
    int         first_random;
    int         phase;
    logic [6:0] len;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, too few symbols, then radix two at the number extremes.
    plan.push_back(rejected_row(32'sd0));
    plan.push_back(length_row(7'd1));
    plan.push_back(load_row(6'd0, "0"));
    plan.push_back(rejected_row(32'sd5));
    plan.push_back(length_row(7'd2));
    plan.push_back(load_row(6'd1, "1"));
    plan.push_back(convert_row(32'sd0));
    plan.push_back(convert_row(32'sh8000_0000));
    plan.push_back(convert_row(32'sh7fff_ffff));
    plan.push_back(convert_row(-32'sd1));
    // Each kind of bad symbol, then a repeated one.
    plan.push_back(load_row(6'd1, CharSpace));
    plan.push_back(rejected_row(32'sd1));
    plan.push_back(load_row(6'd1, CharDel));
    plan.push_back(rejected_row(32'sd1));
    plan.push_back(load_row(6'd1, CharPlus));
    plan.push_back(rejected_row(-32'sd1));
    plan.push_back(load_row(6'd1, CharMinus));
    plan.push_back(rejected_row(32'sd7));
    plan.push_back(load_row(6'd1, 8'd0));
    plan.push_back(rejected_row(32'sd2));
    plan.push_back(load_row(6'd1, 8'd255));
    plan.push_back(rejected_row(32'sh8000_0000));
    plan.push_back(load_row(6'd1, "0"));
    plan.push_back(rejected_row(32'sd3));
    // Lowest and highest printable codes.
    plan.push_back(load_row(6'd1, "!"));
    plan.push_back(convert_row(32'sd2));
    plan.push_back(load_row(6'd0, "~"));
    plan.push_back(convert_row(-32'sd3));

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        write_length(plan[i].length);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // The full-size alphabet comes first so that every table entry is loaded
    // before the other lengths run.
    first_random = beats_in;
    phase = 0;
    while (beats_in - first_random < RandomBeats) begin
      case (phase)
        0:       len = 7'd64;
        1:       len = 7'd2;
        2:       len = 7'd127;
        3:       len = 7'd10;
        4:       len = 7'd65;
        5:       len = 7'd1;
        6:       len = 7'd0;
        7:       len = 7'd16;
        default: len = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(21, 64))
                                                    : 7'($urandom_range(3, 20));
      endcase
      run_phase(len);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d input beats, %0d of them conversions, under %0d alphabet lengths.",
             beats_in, conversions, lengths_set);
    $display("Checked %0d output beats, %0d field mismatches.", beats_out, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
